>>> sv/a2u_pkg.sv
// ----------------------------------------------------------------------------
// a2u_pkg: shared definitions for the ASCII to unsigned parser
// Character codes, base codes, parse phases and small decode helpers.
// ----------------------------------------------------------------------------
package a2u_pkg;

    // Field widths fixed by the stream format
    localparam int CH_W    = 8;
    localparam int RADIX_W = 6;
    localparam int STOP_W  = 11;

    // Defaults for the top-level parameters
    localparam int MAX_LEN_DEF    = 1024;
    localparam int VALUE_BITS_DEF = 64;

    // Radix register reset value
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    // Base codes
    localparam logic [RADIX_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [RADIX_W-1:0] BASE_ONE  = 6'd1;
    localparam logic [RADIX_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [RADIX_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [RADIX_W-1:0] BASE_HEX  = 6'd16;
    localparam logic [RADIX_W-1:0] BASE_MAX  = 6'd36;

    // Digit value that no base accepts
    localparam logic [RADIX_W-1:0] DIGIT_NONE = 6'd63;
    localparam logic [RADIX_W-1:0] DIGIT_TEN  = 6'd10;

    // Character codes
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_0     = 8'h30;
    localparam logic [CH_W-1:0] CH_9     = 8'h39;
    localparam logic [CH_W-1:0] CH_UA    = 8'h41;
    localparam logic [CH_W-1:0] CH_UX    = 8'h58;
    localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CH_W-1:0] CH_LA    = 8'h61;
    localparam logic [CH_W-1:0] CH_LX    = 8'h78;
    localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;

    // Parse phase, one-hot
    typedef enum logic [4:0] {
        PH_SPACE  = 5'b00001,
        PH_SIGNED = 5'b00010,
        PH_ZERO   = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_HALTED = 5'b10000
    } phase_t;

    // Whitespace: tab through carriage return, and space
    function automatic logic is_space(input logic [CH_W-1:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

    // Base 1 and anything above 36 cannot be used
    function automatic logic base_invalid(input logic [RADIX_W-1:0] b);
        return (b == BASE_ONE) || (b > BASE_MAX);
    endfunction

    // Map 0-9, A-Z, a-z to 0..35; everything else to a value no base accepts
    function automatic logic [RADIX_W-1:0] digit_value(input logic [CH_W-1:0] c);
        logic [RADIX_W-1:0] d;
        d = DIGIT_NONE;
        if ((c >= CH_0) && (c <= CH_9))
        begin
            d = RADIX_W'(c - CH_0);
        end
        else if ((c >= CH_UA) && (c <= CH_UZ))
        begin
            d = RADIX_W'(c - CH_UA) + DIGIT_TEN;
        end
        else if ((c >= CH_LA) && (c <= CH_LZ))
        begin
            d = RADIX_W'(c - CH_LA) + DIGIT_TEN;
        end
        return d;
    endfunction

endpackage

>>> sv/a2u_in_stage.sv
// ----------------------------------------------------------------------------
// a2u_in_stage: input word register
// Holds one character word; takes a new one when empty or whenever the held word moves on.
// ----------------------------------------------------------------------------
module a2u_in_stage
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [a2u_pkg::CH_W-1:0]  s_tdata,
    input  logic                      consume,
    output logic                      ch_valid,
    output logic [a2u_pkg::CH_W-1:0]  ch
);

    logic                     valid_reg;
    logic                     valid_next;
    logic [a2u_pkg::CH_W-1:0] ch_reg;
    logic                     load;

    // Accept when empty or when the held word leaves this cycle
    assign s_tready = !valid_reg || consume;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload: capture on accept
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ch_reg <= s_tdata;
        end
    end

    assign ch_valid = valid_reg;
    assign ch       = ch_reg;

endmodule

>>> sv/a2u_parse.sv
// ----------------------------------------------------------------------------
// a2u_parse: per-character parse state and result formation
// Updates the phase, accumulator, sign and error state for one character
// per cycle while step is high, and forms the result when the terminator arrives.
// ----------------------------------------------------------------------------
module a2u_parse
#(
    parameter int MAX_LEN    = a2u_pkg::MAX_LEN_DEF,
    parameter int VALUE_BITS = a2u_pkg::VALUE_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [a2u_pkg::RADIX_W-1:0]  cfg_wdata,
    input  logic                         step,
    input  logic [a2u_pkg::CH_W-1:0]     ch,
    output logic                         res_valid,
    output logic [VALUE_BITS-1:0]        res_value,
    output logic                         res_failed,
    output logic [a2u_pkg::STOP_W-1:0]   res_stop
);

    localparam int IDX_W = $clog2(MAX_LEN + 1);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_LEN);

    logic [a2u_pkg::RADIX_W-1:0] radix_reg;
    a2u_pkg::phase_t             phase_reg;
    a2u_pkg::phase_t             phase_next;
    logic [VALUE_BITS-1:0]       acc_reg;
    logic [VALUE_BITS-1:0]       acc_next;
    logic                        minus_reg;
    logic                        minus_next;
    logic [a2u_pkg::RADIX_W-1:0] base_reg;
    logic [a2u_pkg::RADIX_W-1:0] base_next;
    logic [IDX_W-1:0]            idx_reg;
    logic [IDX_W-1:0]            idx_next;
    logic                        err_reg;
    logic                        err_next;
    logic [IDX_W-1:0]            stop_reg;
    logic [IDX_W-1:0]            stop_next;

    logic                        is_term;
    logic [a2u_pkg::RADIX_W-1:0] digit;
    logic [a2u_pkg::RADIX_W-1:0] take_base;
    logic                        take;
    logic                        begin_num;
    logic [VALUE_BITS+a2u_pkg::RADIX_W-1:0] prod;
    logic [VALUE_BITS-1:0]       mac;
    logic                        res_bad;

    assign is_term = (ch == a2u_pkg::CH_NUL);
    assign digit   = a2u_pkg::digit_value(ch);

    // One multiply-add for the digit taken this cycle
    assign prod = acc_reg * take_base;
    assign mac  = prod[VALUE_BITS-1:0] + VALUE_BITS'(digit);

    // Result on terminator
    always_comb
    begin
        res_bad = err_reg ||
                  (((phase_reg == a2u_pkg::PH_SPACE) || (phase_reg == a2u_pkg::PH_SIGNED)) &&
                   a2u_pkg::base_invalid(radix_reg));
        res_valid  = step && is_term;
        res_failed = res_bad;
        res_stop   = a2u_pkg::STOP_W'(err_reg ? stop_reg : idx_reg);
        if (res_bad)
        begin
            res_value = '1;
        end
        else if (minus_reg)
        begin
            res_value = (~acc_reg) + VALUE_BITS'(1);
        end
        else
        begin
            res_value = acc_reg;
        end
    end

    // Next state for one character
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        minus_next = minus_reg;
        base_next  = base_reg;
        idx_next   = idx_reg;
        err_next   = err_reg;
        stop_next  = stop_reg;
        take       = 1'b0;
        take_base  = base_reg;
        begin_num  = 1'b0;

        // Decide phase transition and whether a digit is taken
        unique case (phase_reg)
            a2u_pkg::PH_SPACE:
            begin
                if (a2u_pkg::is_space(ch))
                begin
                    phase_next = a2u_pkg::PH_SPACE;
                end
                else if ((ch == a2u_pkg::CH_PLUS) || (ch == a2u_pkg::CH_MINUS))
                begin
                    minus_next = (ch == a2u_pkg::CH_MINUS);
                    phase_next = a2u_pkg::PH_SIGNED;
                end
                else
                begin
                    begin_num = 1'b1;
                end
            end
            a2u_pkg::PH_SIGNED:
            begin
                begin_num = 1'b1;
            end
            a2u_pkg::PH_ZERO:
            begin
                if ((ch == a2u_pkg::CH_LX) || (ch == a2u_pkg::CH_UX))
                begin
                    base_next  = a2u_pkg::BASE_HEX;
                    phase_next = a2u_pkg::PH_DIGITS;
                end
                else
                begin
                    take_base  = (base_reg == a2u_pkg::BASE_AUTO) ? a2u_pkg::BASE_OCT
                                                                  : base_reg;
                    base_next  = take_base;
                    phase_next = a2u_pkg::PH_DIGITS;
                    take       = 1'b1;
                end
            end
            a2u_pkg::PH_DIGITS:
            begin
                take = 1'b1;
            end
            a2u_pkg::PH_HALTED:
            begin
                phase_next = a2u_pkg::PH_HALTED;
            end
            default:
            begin
                phase_next = a2u_pkg::PH_HALTED;
            end
        endcase

        // Start of the number: sample the radix
        if (begin_num)
        begin
            if (a2u_pkg::base_invalid(radix_reg))
            begin
                err_next   = 1'b1;
                stop_next  = idx_reg;
                phase_next = a2u_pkg::PH_HALTED;
            end
            else if (((radix_reg == a2u_pkg::BASE_AUTO) || (radix_reg == a2u_pkg::BASE_HEX)) &&
                     (ch == a2u_pkg::CH_0))
            begin
                base_next  = radix_reg;
                phase_next = a2u_pkg::PH_ZERO;
            end
            else
            begin
                take_base  = (radix_reg == a2u_pkg::BASE_AUTO) ? a2u_pkg::BASE_DEC : radix_reg;
                base_next  = take_base;
                phase_next = a2u_pkg::PH_DIGITS;
                take       = 1'b1;
            end
        end

        // Take a digit or stop on a bad one
        if (take)
        begin
            if (digit >= take_base)
            begin
                err_next   = 1'b1;
                stop_next  = idx_reg;
                phase_next = a2u_pkg::PH_HALTED;
            end
            else
            begin
                acc_next = mac;
            end
        end

        // Advance the saturating position
        if (idx_reg < IDX_MAX)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end

        // Terminator: clear for the next string
        if (is_term)
        begin
            phase_next = a2u_pkg::PH_SPACE;
            acc_next   = '0;
            minus_next = 1'b0;
            base_next  = a2u_pkg::BASE_AUTO;
            idx_next   = '0;
            err_next   = 1'b0;
            stop_next  = '0;
        end
    end

    // Radix register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= a2u_pkg::RADIX_RESET;
        end
        else if (cfg_we)
        begin
            radix_reg <= cfg_wdata;
        end
    end

    // Parse state: advance once per consumed character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= a2u_pkg::PH_SPACE;
            acc_reg   <= '0;
            minus_reg <= 1'b0;
            base_reg  <= a2u_pkg::BASE_AUTO;
            idx_reg   <= '0;
            err_reg   <= 1'b0;
            stop_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            minus_reg <= minus_next;
            base_reg  <= base_next;
            idx_reg   <= idx_next;
            err_reg   <= err_next;
            stop_reg  <= stop_next;
        end
    end

endmodule

>>> sv/a2u_out_stage.sv
// ----------------------------------------------------------------------------
// a2u_out_stage: result word register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module a2u_out_stage
#(
    parameter int DATA_W = 80
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [DATA_W-1:0] load_data,
    output logic              free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata
);

    logic              valid_reg;
    logic              valid_next;
    logic [DATA_W-1:0] data_reg;

    // Room for a new word when empty or when the held one is taken now
    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload: capture a new result
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

>>> sv/ascii_to_unsigned_parser.sv
// ----------------------------------------------------------------------------
// ascii_to_unsigned_parser: streaming string to unsigned integer parser
// Parses a zero-terminated ASCII string, one character per word, and emits
// one result word per string.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle with no gaps between strings, except
// that a terminator waits in the input register until the result register has room.
// Each accepted character is held in the input register; the parse state is then
// updated by a single multiply-add of the accumulator by the base, which is the loop
// that sets the one-character-per-cycle rate. The result of a string is registered
// on the master side when its zero terminator is consumed and holds there until
// taken; while a result waits, non-terminator characters keep flowing. The radix is
// sampled at the first character after leading whitespace and sign, so write
// it only between strings. No clearing pass follows reset.
module ascii_to_unsigned_parser
#(
    parameter int MAX_LEN    = a2u_pkg::MAX_LEN_DEF,
    parameter int VALUE_BITS = a2u_pkg::VALUE_BITS_DEF,
    localparam int OUT_W     = ((VALUE_BITS + 1 + a2u_pkg::STOP_W + 7) / 8) * 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // Configuration: radix
    input  logic                         cfg_we,
    input  logic [a2u_pkg::RADIX_W-1:0]  cfg_wdata,
    // Character input
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [a2u_pkg::CH_W-1:0]     s_axis_tdata,   // ch
    // Result output
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [OUT_W-1:0]             m_axis_tdata    // value, failed, stop_position, zero pad
);

    localparam int PAD_W = OUT_W - VALUE_BITS - 1 - a2u_pkg::STOP_W;

    logic                        ch_valid;
    logic [a2u_pkg::CH_W-1:0]    ch;
    logic                        consume;
    logic                        is_term;
    logic                        out_free;
    logic                        res_valid;
    logic [VALUE_BITS-1:0]       res_value;
    logic                        res_failed;
    logic [a2u_pkg::STOP_W-1:0]  res_stop;
    logic [OUT_W-1:0]            res_word;

    // Hold a terminator until the result register has room
    assign is_term = (ch == a2u_pkg::CH_NUL);
    assign consume = ch_valid && (!is_term || out_free);

    a2u_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .consume  (consume),
        .ch_valid (ch_valid),
        .ch       (ch)
    );

    a2u_parse
    #(
        .MAX_LEN    (MAX_LEN),
        .VALUE_BITS (VALUE_BITS)
    )
    u_parse
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .step       (consume),
        .ch         (ch),
        .res_valid  (res_valid),
        .res_value  (res_value),
        .res_failed (res_failed),
        .res_stop   (res_stop)
    );

    // Pack the result word, first field in the lowest bits
    assign res_word = {PAD_W'(0), res_stop, res_failed, res_value};

    a2u_out_stage
    #(
        .DATA_W (OUT_W)
    )
    u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_data (res_word),
        .free      (out_free),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // A consumed terminator always shows a result next cycle
    a_term_result: assert property (@(posedge clk) disable iff (!rst_n)
        (ch_valid && is_term && consume) |=> m_axis_tvalid)
        else $error("terminator consumed without a result");

    // A failed result carries the all-ones value
    a_fail_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[VALUE_BITS]) |-> (m_axis_tdata[VALUE_BITS-1:0] == '1))
        else $error("failed result without all-ones value");

    // The stop position never passes the maximum length, checked when MAX_LEN is below 2048
    a_stop_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((MAX_LEN >= 2048) ||
            (m_axis_tdata[VALUE_BITS+a2u_pkg::STOP_W:VALUE_BITS+1] <= a2u_pkg::STOP_W'(MAX_LEN))))
        else $error("stop position beyond maximum length");

    // Input stalls only while a word is held
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (ch_valid && is_term && m_axis_tvalid))
        else $error("input stalled without a held terminator");
`endif

endmodule
